>>> rtl/sha1_pkg.sv
// shared types and constants of the sha-1 hash engine
// used by sha1_window, sha1_round, sha1_hash_engine and the testbench; no dependencies
`default_nettype none

package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int WIN_WORDS = 16;
    localparam int WIN_W    = WORD_W * WIN_WORDS;
    localparam int ROUNDS   = 80;
    localparam int ROUND_W  = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 5;
    localparam int IDX_W    = 3;
    localparam int COUNT_W  = 64;
    localparam int POS_W    = 6;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam t_word IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam logic [1:0] OP_ABSORB      = 2'd0;
    localparam logic [1:0] OP_ABSORB_LAST = 2'd1;
    localparam logic [1:0] OP_END         = 2'd2;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
    localparam int PAD_END = 56;

endpackage

`default_nettype wire

>>> rtl/sha1_window.sv
// sixteen-word message window: bytes shift in while a block fills,
// words shift through it during the rounds; uses sha1_pkg
`default_nettype none

module sha1_window (
    input  wire                     i_clk,
    input  wire                     i_byte_en,
    input  wire [sha1_pkg::BYTE_W-1:0] i_byte,
    input  wire                     i_word_en,
    input  wire sha1_pkg::t_word    i_word,
    output sha1_pkg::t_word         o_w0,
    output sha1_pkg::t_word         o_w2,
    output sha1_pkg::t_word         o_w8,
    output sha1_pkg::t_word         o_w13
);
    import sha1_pkg::*;

    // word j of the window sits at bits [WIN_W-1-WORD_W*j -: WORD_W]
    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] n_win;

    always_comb begin
        n_win = r_win;
        if (i_byte_en) begin
            n_win = {r_win[WIN_W-BYTE_W-1:0], i_byte};
        end else if (i_word_en) begin
            n_win = {r_win[WIN_W-WORD_W-1:0], i_word};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_w0  = r_win[WIN_W-1            -: WORD_W];
    assign o_w2  = r_win[WIN_W-1-WORD_W*2   -: WORD_W];
    assign o_w8  = r_win[WIN_W-1-WORD_W*8   -: WORD_W];
    assign o_w13 = r_win[WIN_W-1-WORD_W*13  -: WORD_W];

endmodule

`default_nettype wire

>>> rtl/sha1_round.sv
// one sha-1 round: schedule word, round function, constant and add chain
// reused for all 80 rounds; uses sha1_pkg
`default_nettype none

module sha1_round (
    input  wire [sha1_pkg::ROUND_W-1:0] i_round,
    input  wire sha1_pkg::t_vars    i_vars,
    input  wire sha1_pkg::t_word    i_w0,
    input  wire sha1_pkg::t_word    i_w2,
    input  wire sha1_pkg::t_word    i_w8,
    input  wire sha1_pkg::t_word    i_w13,
    output sha1_pkg::t_vars         o_vars,
    output sha1_pkg::t_word         o_w
);
    import sha1_pkg::*;

    t_word mix;
    t_word w;
    t_word f;
    t_word k;
    t_word tmp;

    always_comb begin
        mix = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
        // first sixteen rounds take the block words as they are
        if (i_round < ROUND_W'(16)) begin
            w = i_w0;
        end else begin
            w = {mix[WORD_W-2:0], mix[WORD_W-1]};
        end

        case (i_round) inside
            [ROUND_W'(0):ROUND_W'(19)]: begin
                f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
                k = K0;
            end
            [ROUND_W'(20):ROUND_W'(39)]: begin
                f = i_vars.b ^ i_vars.c ^ i_vars.d;
                k = K1;
            end
            [ROUND_W'(40):ROUND_W'(59)]: begin
                f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
                k = K2;
            end
            default: begin
                f = i_vars.b ^ i_vars.c ^ i_vars.d;
                k = K3;
            end
        endcase

        tmp = {i_vars.a[WORD_W-6:0], i_vars.a[WORD_W-1:WORD_W-5]} + f + i_vars.e + k + w;

        o_vars.a = tmp;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[WORD_W-1:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
        o_w      = w;
    end

endmodule

`default_nettype wire

>>> rtl/sha1_hash_engine.sv
// sha-1 hash engine top level: byte intake, padding sequencer, round
// sequencing and digest output; uses sha1_pkg, sha1_window, sha1_round
`default_nettype none

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_operation, i_data_byte
// digest    out        o_valid / i_stall   o_digest_word, o_word_index, o_last_word
//
// message bytes are taken while the engine is idle; the 64th byte of a
// block starts the compression, all rounds through the single shared round
// unit, then a fold of the round variables into the chaining value
// end of message feeds the padding bytes one per cycle, while no compression
// runs, through the same intake path (one or two compressions), then offers
// five digest words, one transfer each; the input stalls for all of that time
// reset is synchronous, active low, and loads the initial hash values

module sha1_hash_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [1:0]  i_operation,
    input  wire [7:0]  i_data_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0] o_word_index,
    output logic       o_last_word
);
    import sha1_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD80  = 3'd1;
    localparam logic [2:0] S_PADZ   = 3'd2;
    localparam logic [2:0] S_PADLEN = 3'd3;
    localparam logic [2:0] S_COMP   = 3'd4;
    localparam logic [2:0] S_ADD    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(63);
    localparam logic [POS_W-1:0] POS_PRELEN = POS_W'(PAD_END - 1);

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_after, n_after;     // where to resume after a compression
    logic [COUNT_W-1:0] r_count, n_count;     // bit count of absorbed bytes, padding included
    logic [COUNT_W-1:0] r_total, n_total;     // length field, shifted out msb first
    logic [ROUND_W-1:0] r_round, n_round;
    logic [IDX_W-1:0]   r_idx, n_idx;         // digest word on offer
    logic [2:0]         r_len, n_len;         // length byte counter
    t_vars              r_vars, n_vars;
    t_word              r_chain [DIGEST_WORDS];
    t_word              n_chain [DIGEST_WORDS];

    logic               in_xfer;
    logic               out_xfer;
    logic               absorb_en;
    logic [BYTE_W-1:0]  absorb_byte;
    logic               win_word_en;
    logic [POS_W-1:0]   pos;

    t_word              w0, w2, w8, w13;
    t_vars              round_vars;
    t_word              round_w;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;
    assign pos      = r_count[POS_W+2:3];

    sha1_window u_window (
        .i_clk     (i_clk),
        .i_byte_en (absorb_en),
        .i_byte    (absorb_byte),
        .i_word_en (win_word_en),
        .i_word    (round_w),
        .o_w0      (w0),
        .o_w2      (w2),
        .o_w8      (w8),
        .o_w13     (w13)
    );

    sha1_round u_round (
        .i_round (r_round),
        .i_vars  (r_vars),
        .i_w0    (w0),
        .i_w2    (w2),
        .i_w8    (w8),
        .i_w13   (w13),
        .o_vars  (round_vars),
        .o_w     (round_w)
    );

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_count     = r_count;
        n_total     = r_total;
        n_round     = r_round;
        n_idx       = r_idx;
        n_len       = r_len;
        n_vars      = r_vars;
        n_chain     = r_chain;
        absorb_en   = 1'b0;
        absorb_byte = i_data_byte;
        win_word_en = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_operation)
                        OP_ABSORB: begin
                            absorb_en = 1'b1;
                        end
                        OP_ABSORB_LAST: begin
                            absorb_en = 1'b1;
                            n_total   = r_count + COUNT_W'(8);
                            n_state   = S_PAD80;
                        end
                        OP_END: begin
                            n_total = r_count;
                            n_state = S_PAD80;
                        end
                        default: begin
                            // unused code: transfer taken, nothing happens
                        end
                    endcase
                end
            end
            S_PAD80: begin
                absorb_en   = 1'b1;
                absorb_byte = PAD_BYTE;
                n_len       = '0;
                n_state     = (pos == POS_PRELEN) ? S_PADLEN : S_PADZ;
            end
            S_PADZ: begin
                absorb_en   = 1'b1;
                absorb_byte = ZERO_BYTE;
                n_state     = (pos == POS_PRELEN) ? S_PADLEN : S_PADZ;
            end
            S_PADLEN: begin
                absorb_en   = 1'b1;
                absorb_byte = r_total[COUNT_W-1 -: BYTE_W];
                n_total     = {r_total[COUNT_W-BYTE_W-1:0], ZERO_BYTE};
                n_len       = r_len + 3'd1;
                n_idx       = '0;
                n_state     = (r_len == 3'd7) ? S_OUT : S_PADLEN;
            end
            S_COMP: begin
                win_word_en = 1'b1;
                n_vars      = round_vars;
                n_round     = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_vars.a;
                n_chain[1] = r_chain[1] + r_vars.b;
                n_chain[2] = r_chain[2] + r_vars.c;
                n_chain[3] = r_chain[3] + r_vars.d;
                n_chain[4] = r_chain[4] + r_vars.e;
                n_state    = r_after;
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_idx == IDX_W'(DIGEST_WORDS - 1)) begin
                        // back to initial values for the next message
                        n_chain = IV;
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // every byte, message or padding, goes through here
        if (absorb_en) begin
            n_count = r_count + COUNT_W'(8);
            if (pos == POS_LAST) begin
                n_after = n_state;
                n_state = S_COMP;
                n_round = '0;
                n_vars  = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                            d: r_chain[3], e: r_chain[4]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_len   <= '0;
            r_chain <= IV;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_count <= n_count;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_chain <= n_chain;
        end
    end

    // working payload, no reset
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_vars  <= n_vars;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == IDX_W'(DIGEST_WORDS - 1));

endmodule

`default_nettype wire

>>> tb/sha1_digest_checker.sv
// digest checker for the sha-1 hash engine: watches both channels, keeps its
// own hash state and compares every digest word with the oldest expected one
// depends on sha1_pkg for word type, round constants and operation codes

module sha1_digest_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire [1:0]  i_in_op,
    input  wire [7:0]  i_in_byte,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire [31:0] i_out_word,
    input  wire [2:0]  i_out_idx,
    input  wire        i_out_last,
    output int         o_fail_count,
    output int         o_expected_left,
    output int         o_words_checked,
    output int         o_messages
);
    import sha1_pkg::*;

    typedef struct packed {
        t_word      word;
        logic [2:0] idx;
        logic       last;
    } t_digest_word;

    t_word        chain [DIGEST_WORDS];
    logic [7:0]   blk [64];
    logic [63:0]  msg_bits;
    t_digest_word digest_q [$];
    t_digest_word want;

    int fail_cnt  = 0;
    int pend_cnt  = 0;
    int word_cnt  = 0;
    int msg_cnt   = 0;

    assign o_fail_count    = fail_cnt;
    assign o_expected_left = pend_cnt;
    assign o_words_checked = word_cnt;
    assign o_messages      = msg_cnt;

    function automatic void restart_hash();
        for (int i = 0; i < DIGEST_WORDS; i++)
            chain[i] = IV[i];
        msg_bits = '0;
    endfunction

    function automatic void compress_block();
        t_word w [16];
        t_word a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            // rolling 16-word schedule
            if (t >= 16) begin
                tmp = w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16];
                w[t%16] = {tmp[30:0], tmp[31]};
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t%16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        logic [5:0] pos;
        pos = msg_bits[8:3];
        blk[pos] = value;
        msg_bits += 64'd8;
        if (pos == 6'd63)
            compress_block();
    endfunction

    function automatic void finish_message();
        logic [63:0]  total;
        t_digest_word dw;
        total = msg_bits;
        absorb_byte(PAD_BYTE);
        while (msg_bits[8:3] != PAD_END)
            absorb_byte(ZERO_BYTE);
        for (int i = 0; i < 8; i++)
            absorb_byte(total[8*(7-i) +: 8]);
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            dw.word = chain[i];
            dw.idx  = 3'(i);
            dw.last = (i == DIGEST_WORDS - 1);
            digest_q.push_back(dw);
        end
        msg_cnt++;
        restart_hash();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (i_in_op)
                    OP_ABSORB: absorb_byte(i_in_byte);
                    OP_ABSORB_LAST: begin
                        absorb_byte(i_in_byte);
                        finish_message();
                    end
                    OP_END: finish_message();
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h (index %0d) with no expected word waiting",
                           i_out_word, i_out_idx);
                    fail_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    word_cnt++;
                    if (i_out_word !== want.word) begin
                        $error("digest_word: expected %h, got %h", want.word, i_out_word);
                        fail_cnt++;
                    end
                    if (i_out_idx !== want.idx) begin
                        $error("word_index: expected %0d, got %0d", want.idx, i_out_idx);
                        fail_cnt++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last_word: expected %0d, got %0d", want.last, i_out_last);
                        fail_cnt++;
                    end
                end
            end
        end
        pend_cnt = digest_q.size();
    end

endmodule

>>> tb/tb.sv
// top of the sha-1 hash engine testbench: clock, reset, message stimulus,
// output stall pattern and verdict; checking lives in sha1_digest_checker
// depends on sha1_pkg, sha1_hash_engine and sha1_digest_checker

module tb;
    import sha1_pkg::*;

    // the fourth operation code has no meaning and must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_CYCLES  = 400;  // long output hold-off
    localparam int PHASE_ITEMS  = 50;   // counted transfers per idling phase
    localparam int SETTLE       = 8;    // quiet cycles after a drain
    localparam int END_CYCLES   = 400;  // two compressions plus padding, with margin

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_op;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_word;
    logic [2:0]  out_idx;
    logic        out_last;

    int fail_count;
    int expected_left;
    int words_checked;
    int messages;

    int idle_pct     = 0;  // chance per cycle that the sender holds back
    int stall_pct    = 0;  // chance per cycle that the receiver stalls
    int hold_reqs    = 0;  // bumped by the stimulus to ask for a hold-off
    int hold_done    = 0;
    int hold_left    = 0;
    int items_sent   = 0;  // byte and end-of-message transfers
    int ignored_sent = 0;  // transfers with the unused code
    int phase_start  = 0;

    sha1_hash_engine dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_operation   (in_op),
        .i_data_byte   (in_byte),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_digest_word (out_word),
        .o_word_index  (out_idx),
        .o_last_word   (out_last)
    );

    sha1_digest_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_op         (in_op),
        .i_in_byte       (in_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .i_out_idx       (out_idx),
        .i_out_last      (out_last),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left),
        .o_words_checked (words_checked),
        .o_messages      (messages)
    );

    // 8-unit period, low half first
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver side: random stalls, or a counted hold-off when one is asked for
    // while held, an engine with a digest on offer keeps it and stops taking input bytes
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_reqs;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // one transfer on the input channel; called at a falling edge, returns at one
    // valid only drops during a sender gap, so it never falls and rises in one step
    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_byte  <= value;
        // payload holds until a rising edge without stall
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (op == OP_UNUSED)
            ignored_sent++;
        else
            items_sent++;
    endtask

    // a whole message of random bytes, ended either on its last byte or by a
    // separate end transfer; unused codes are sprinkled in as noise
    task automatic send_message(input int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(15) == 0)
                send_item(OP_UNUSED, 8'($urandom));
            if (end_on_byte && n == len - 1)
                send_item(OP_ABSORB_LAST, 8'($urandom));
            else
                send_item(OP_ABSORB, 8'($urandom));
        end
        if (!end_on_byte)
            send_item(OP_END, 8'($urandom));
    endtask

    // mostly short messages; some sit on the one/two compression and full
    // block boundaries, a few run across a block
    function automatic int pick_len();
        int r;
        int marks [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        r = $urandom_range(9);
        if (r < 7)
            return $urandom_range(12);
        else if (r < 9)
            return marks[$urandom_range(7)];
        else
            return $urandom_range(70, 13);
    endfunction

    // sender pause: nothing offered until every digest word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_op    = OP_ABSORB;
        in_byte  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        send_item(OP_END, 8'hFF);              // empty message, byte ignored
        send_item(OP_ABSORB, 8'h61);           // "abc"
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB_LAST, 8'h63);
        send_item(OP_UNUSED, 8'hFF);           // unused code alone changes nothing
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_END, 8'h00);              // still the empty message
        send_item(OP_ABSORB_LAST, 8'h00);      // one-byte messages at the extremes
        send_item(OP_ABSORB_LAST, 8'hFF);
        send_item(OP_ABSORB, 8'hA5);           // unused code inside a message
        send_item(OP_UNUSED, 8'h5A);
        send_item(OP_ABSORB_LAST, 8'h3C);
        send_item(OP_ABSORB, 8'h80);           // bytes then a separate end
        send_item(OP_ABSORB, 8'h7F);
        send_item(OP_END, 8'h00);
        // a 64-bit bit count overflow needs 2^61 bytes and is out of reach here
        drain();

        // random messages under four idling mixes, drained between phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 76;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 76;
                end
                default: begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_message(pick_len());
            drain();
        end

        // long receiver hold-off while short messages keep coming, so the
        // engine backs up and stalls its input
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs++;
        repeat (3) send_message($urandom_range(10));
        drain();

        // let any stray output show up before the verdict
        repeat (END_CYCLES) @(negedge clk);
        $display("covered %0d messages over %0d byte/end transfers and %0d unused codes",
                 messages, items_sent, ignored_sent);
        $display("%0d digest words compared under four idle mixes and a %0d-cycle hold",
                 words_checked, HOLD_CYCLES);
        if (fail_count == 0 && expected_left == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sha1_hash_engine.f
rtl/sha1_pkg.sv
rtl/sha1_window.sv
rtl/sha1_round.sv
rtl/sha1_hash_engine.sv
tb/sha1_digest_checker.sv
tb/tb.sv
